// File: sv/swqt_pkg.sv
// Shared constants, types and codes of the sliding-window quantile tracker.
`timescale 1ns / 1ps
`default_nettype none
package swqt_pkg;

    localparam int WINDOW_MAX  = 2048;
    localparam int ADDR_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SAMPLE_W    = 32;
    localparam int PCT_W       = 7;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int PROD_W      = PCT_W + ADDR_W;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for every x below 2^PROD_W
    localparam int RECIP_SHIFT = 25;
    localparam int RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] RECIP = 19'd335545;

    localparam logic [CNT_W-1:0] WINDOW_MAX_CNT = CNT_W'(WINDOW_MAX);

    localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RST = 12'd2048;
    localparam logic [CFG_DATA_W-1:0] WARMUP_LENGTH_RST = 12'd250;
    localparam logic [PCT_W-1:0]      LOW_PERCENT_RST   = 7'd15;
    localparam logic [PCT_W-1:0]      MID_PERCENT_RST   = 7'd50;
    localparam logic [PCT_W-1:0]      HIGH_PERCENT_RST  = 7'd85;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_LENGTH = 3'd0,
        CFG_WARMUP_LENGTH = 3'd1,
        CFG_LOW_PERCENT   = 3'd2,
        CFG_MID_PERCENT   = 3'd3,
        CFG_HIGH_PERCENT  = 3'd4
    } cfg_index_t;

    // Which of the three order statistics is being picked
    typedef enum logic [1:0] {
        PICK_LOW  = 2'd0,
        PICK_MID  = 2'd1,
        PICK_HIGH = 2'd2
    } pick_t;

    // Effective settings after clamping
    typedef struct packed {
        logic [CNT_W-1:0] cap;
        logic             cap_full;
        logic [CNT_W-1:0] warm;
        logic [PCT_W-1:0] low_pct;
        logic [PCT_W-1:0] mid_pct;
        logic [PCT_W-1:0] high_pct;
    } cfg_t;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_RRD   = 11'b000_0000_0010,
        ST_RWAIT = 11'b000_0000_0100,
        ST_DEL   = 11'b000_0000_1000,
        ST_INIT  = 11'b000_0001_0000,
        ST_INS   = 11'b000_0010_0000,
        ST_PK0   = 11'b000_0100_0000,
        ST_PK1   = 11'b000_1000_0000,
        ST_PK2   = 11'b001_0000_0000,
        ST_PK3   = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } state_t;

endpackage
`default_nettype wire

// File: sv/swqt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module swqt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: sv/swqt_cfg.sv
// Configuration registers of the quantile tracker, with range clamping.
`timescale 1ns / 1ps
`default_nettype none
module swqt_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [swqt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [swqt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output swqt_pkg::cfg_t                         cfg
);
    import swqt_pkg::*;

    logic [CFG_DATA_W-1:0] window_length_reg;
    logic [CFG_DATA_W-1:0] warmup_length_reg;
    logic [PCT_W-1:0]      low_percent_reg;
    logic [PCT_W-1:0]      mid_percent_reg;
    logic [PCT_W-1:0]      high_percent_reg;
    logic [CNT_W-1:0]      cap;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_LENGTH_RST;
            warmup_length_reg <= WARMUP_LENGTH_RST;
            low_percent_reg   <= LOW_PERCENT_RST;
            mid_percent_reg   <= MID_PERCENT_RST;
            high_percent_reg  <= HIGH_PERCENT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                CFG_WARMUP_LENGTH: warmup_length_reg <= cfg_data;
                CFG_LOW_PERCENT:   low_percent_reg   <= cfg_data[PCT_W-1:0];
                CFG_MID_PERCENT:   mid_percent_reg   <= cfg_data[PCT_W-1:0];
                CFG_HIGH_PERCENT:  high_percent_reg  <= cfg_data[PCT_W-1:0];
                default:           ;
            endcase
        end
    end

    function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] p);
        return (p > PCT_MAX) ? PCT_MAX : p;
    endfunction

    always_comb
    begin
        // window of zero or one holds one sample; saturate at the memory depth
        if (window_length_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (CNT_W'(window_length_reg) > WINDOW_MAX_CNT)
        begin
            cap = WINDOW_MAX_CNT;
        end
        else
        begin
            cap = CNT_W'(window_length_reg);
        end
        cfg.cap      = cap;
        cfg.cap_full = (cap == WINDOW_MAX_CNT);
        cfg.warm     = (CNT_W'(warmup_length_reg) > cap) ? cap : CNT_W'(warmup_length_reg);
        cfg.low_pct  = sat_pct(low_percent_reg);
        cfg.mid_pct  = sat_pct(mid_percent_reg);
        cfg.high_pct = sat_pct(high_percent_reg);
    end

endmodule
`default_nettype wire

// File: sv/swqt_rank.sv
// Two-stage rank unit: floor(percent * (n - 1) / 100) by reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none
module swqt_rank (
    input  wire logic                         clk,
    input  wire logic [swqt_pkg::PCT_W-1:0]   pct,
    input  wire logic [swqt_pkg::ADDR_W-1:0]  last_index,
    output logic      [swqt_pkg::ADDR_W-1:0]  rank
);
    import swqt_pkg::*;

    logic [PROD_W-1:0]          prod_reg;
    logic [PROD_W+RECIP_W-1:0]  scaled;

    assign scaled = (PROD_W+RECIP_W)'(prod_reg) * (PROD_W+RECIP_W)'(RECIP);

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(pct) * PROD_W'(last_index);
        rank     <= scaled[RECIP_SHIFT +: ADDR_W];
    end

endmodule
`default_nettype wire

// File: sv/sliding_window_quantile_tracker_top.sv
// Top level of the sliding-window quantile tracker: ring store, sorted store and sequencer.
// Usage:
//   s_tvalid/s_tready/s_tdata carry one signed Q16.16 sample per transaction.
//   m_tvalid/m_tready/m_tdata/m_tuser return one result per sample: the low,
//   mid and high order statistics of the window plus the ready and band flags.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the five settings; write them
//   only while no sample is in flight. cfg_ready is always high.
// Operation:
//   The window sits in a ring memory and, kept in order, in a sorted memory.
//   Each sample drops up to two old values from the sorted memory and inserts
//   the new one, each as one pass over the held samples at one entry per
//   cycle; the three picks each step through ST_PK0 to ST_PK3. The result
//   then waits in ST_OUT until the output register is free, and the next
//   sample is accepted after that. One sample is worked at a time.
// Reset: clears the window count and ring position and restores the defaults;
//   no clearing pass is needed, so samples are taken from the first cycle.
// Stall: a result waits in the output register while m_tready is low; the next
//   sample is accepted and worked meanwhile, then waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_quantile_tracker_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,   // [31:0] sample
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [103:0]                      m_tdata,   // [31:0] low_value,
                                                              // [63:32] mid_value,
                                                              // [95:64] high_value,
                                                              // [96] at_or_above_mid,
                                                              // [103:97] zero
    output logic      [1:0]                        m_tuser,   // [0] ready_res,
                                                              // [1] band_valid
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [swqt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [swqt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import swqt_pkg::*;

    cfg_t cfg;

    state_t state_reg;

    logic [CNT_W-1:0]           fill_reg;
    logic [ADDR_W-1:0]          oldest_reg;
    logic [CNT_W-1:0]           m_reg;        // entries now in the sorted store
    logic [1:0]                 rem_cnt_reg;
    logic [ADDR_W-1:0]          rd_ptr_reg;
    logic [ADDR_W-1:0]          wpos_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] del_val_reg;
    logic [CNT_W-1:0]           idx_reg;      // issue counter of a sorted pass
    logic [ADDR_W-1:0]          pidx_reg;     // index of the data now arriving
    logic                       pv_reg;
    logic                       found_reg;
    logic                       done_reg;
    pick_t                      pick_reg;
    logic                       ready_reg;
    logic signed [SAMPLE_W-1:0] low_reg;
    logic signed [SAMPLE_W-1:0] mid_reg;
    logic signed [SAMPLE_W-1:0] high_reg;

    logic                       m_tvalid_reg;
    logic [1:0]                 m_tuser_reg;
    logic [SAMPLE_W*3:0]        m_data_reg;

    logic [SAMPLE_W-1:0]        ring_rd_data;
    logic                       ring_wr_en;
    logic [SAMPLE_W-1:0]        srt_rd_data;
    logic signed [SAMPLE_W-1:0] srt_val;
    logic                       srt_wr_en;
    logic [ADDR_W-1:0]          srt_wr_addr;
    logic [SAMPLE_W-1:0]        srt_wr_data;
    logic [ADDR_W-1:0]          srt_rd_addr;
    logic [ADDR_W-1:0]          rank;
    logic [PCT_W-1:0]           pick_pct;
    logic [ADDR_W-1:0]          last_index;

    logic                       accept;
    logic                       del_end;
    logic                       ins_end;
    logic [CNT_W-1:0]           m_plus;
    logic                       full;
    logic                       band;
    logic                       out_free;

    assign srt_val  = $signed(srt_rd_data);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (fill_reg == WINDOW_MAX_CNT);
    assign del_end  = (idx_reg == m_reg) && !pv_reg;
    assign ins_end  = ((idx_reg == '0) || done_reg) && !pv_reg;
    assign m_plus   = m_reg + CNT_W'(1);
    assign out_free = !m_tvalid_reg || m_tready;
    assign band     = ready_reg && (high_reg > low_reg);
    assign last_index = m_reg[ADDR_W-1:0] - ADDR_W'(1);
    assign ring_wr_en = (state_reg == ST_INIT);

    swqt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        case (pick_reg)
            PICK_LOW:  pick_pct = cfg.low_pct;
            PICK_MID:  pick_pct = cfg.mid_pct;
            PICK_HIGH: pick_pct = cfg.high_pct;
            default:   pick_pct = cfg.high_pct;
        endcase
    end

    swqt_rank u_rank (
        .clk        (clk),
        .pct        (pick_pct),
        .last_index (last_index),
        .rank       (rank)
    );

    swqt_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (wpos_reg),
        .wr_data (sample_reg),
        .rd_addr (rd_ptr_reg),
        .rd_data (ring_rd_data)
    );

    // Sorted store: read address and the single write of each cycle
    always_comb
    begin
        srt_wr_en   = 1'b0;
        srt_wr_addr = pidx_reg;
        srt_wr_data = srt_rd_data;
        case (state_reg)
            ST_DEL:
            begin
                srt_rd_addr = idx_reg[ADDR_W-1:0];
                // close the gap left by the dropped value
                srt_wr_en   = pv_reg && found_reg;
                srt_wr_addr = pidx_reg - ADDR_W'(1);
            end
            ST_INS:
            begin
                srt_rd_addr = idx_reg[ADDR_W-1:0] - ADDR_W'(1);
                if (pv_reg && !done_reg)
                begin
                    srt_wr_en   = 1'b1;
                    srt_wr_addr = pidx_reg + ADDR_W'(1);
                    srt_wr_data = (srt_val > sample_reg) ? srt_rd_data : sample_reg;
                end
                else if (ins_end && !done_reg)
                begin
                    srt_wr_en   = 1'b1;
                    srt_wr_addr = '0;
                    srt_wr_data = sample_reg;
                end
            end
            default:
            begin
                srt_rd_addr = rank;
            end
        endcase
    end

    swqt_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_sorted_ram (
        .clk     (clk),
        .wr_en   (srt_wr_en),
        .wr_addr (srt_wr_addr),
        .wr_data (srt_wr_data),
        .rd_addr (srt_rd_addr),
        .rd_data (srt_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            oldest_reg   <= '0;
            m_reg        <= '0;
            rem_cnt_reg  <= '0;
            rd_ptr_reg   <= '0;
            idx_reg      <= '0;
            pv_reg       <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
            pick_reg     <= PICK_LOW;
            ready_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        m_reg      <= fill_reg;
                        rd_ptr_reg <= oldest_reg;
                        state_reg  <= ST_RRD;
                        if (full)
                        begin
                            // overwrite the oldest; a cut window drops one more
                            wpos_reg <= oldest_reg;
                            if (cfg.cap_full)
                            begin
                                rem_cnt_reg <= 2'd1;
                                oldest_reg  <= oldest_reg + ADDR_W'(1);
                            end
                            else
                            begin
                                rem_cnt_reg <= 2'd2;
                                oldest_reg  <= oldest_reg + ADDR_W'(2);
                                fill_reg    <= fill_reg - CNT_W'(1);
                            end
                        end
                        else
                        begin
                            wpos_reg <= oldest_reg + fill_reg[ADDR_W-1:0];
                            if (fill_reg >= cfg.cap)
                            begin
                                rem_cnt_reg <= 2'd1;
                                oldest_reg  <= oldest_reg + ADDR_W'(1);
                            end
                            else
                            begin
                                rem_cnt_reg <= 2'd0;
                                fill_reg    <= fill_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                ST_RRD:
                begin
                    state_reg <= (rem_cnt_reg == 2'd0) ? ST_INIT : ST_RWAIT;
                end
                ST_RWAIT:
                begin
                    idx_reg   <= '0;
                    pv_reg    <= 1'b0;
                    found_reg <= 1'b0;
                    state_reg <= ST_DEL;
                end
                ST_DEL:
                begin
                    if (idx_reg != m_reg)
                    begin
                        idx_reg  <= idx_reg + CNT_W'(1);
                        pidx_reg <= idx_reg[ADDR_W-1:0];
                        pv_reg   <= 1'b1;
                    end
                    else
                    begin
                        pv_reg <= 1'b0;
                    end
                    if (pv_reg && !found_reg && (srt_val == del_val_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                    if (del_end)
                    begin
                        m_reg       <= m_reg - CNT_W'(1);
                        rem_cnt_reg <= rem_cnt_reg - 2'd1;
                        rd_ptr_reg  <= rd_ptr_reg + ADDR_W'(1);
                        state_reg   <= (rem_cnt_reg == 2'd1) ? ST_INIT : ST_RRD;
                    end
                end
                ST_INIT:
                begin
                    idx_reg   <= m_reg;
                    pv_reg    <= 1'b0;
                    done_reg  <= 1'b0;
                    state_reg <= ST_INS;
                end
                ST_INS:
                begin
                    // walk down from the top, moving larger values up by one
                    if ((idx_reg != '0) && !done_reg)
                    begin
                        idx_reg  <= idx_reg - CNT_W'(1);
                        pidx_reg <= idx_reg[ADDR_W-1:0] - ADDR_W'(1);
                        pv_reg   <= 1'b1;
                    end
                    else
                    begin
                        pv_reg <= 1'b0;
                    end
                    if (pv_reg && !done_reg && !(srt_val > sample_reg))
                    begin
                        done_reg <= 1'b1;
                    end
                    if (ins_end)
                    begin
                        m_reg     <= m_plus;
                        ready_reg <= (m_plus >= cfg.warm);
                        pick_reg  <= PICK_LOW;
                        if (m_plus >= cfg.warm)
                        begin
                            state_reg <= ST_PK0;
                        end
                        else
                        begin
                            low_reg   <= '0;
                            mid_reg   <= '0;
                            high_reg  <= '0;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_PK0:
                begin
                    state_reg <= ST_PK1;
                end
                ST_PK1:
                begin
                    state_reg <= ST_PK2;
                end
                ST_PK2:
                begin
                    state_reg <= ST_PK3;
                end
                ST_PK3:
                begin
                    case (pick_reg)
                        PICK_LOW:
                        begin
                            low_reg   <= srt_val;
                            pick_reg  <= PICK_MID;
                            state_reg <= ST_PK0;
                        end
                        PICK_MID:
                        begin
                            mid_reg   <= srt_val;
                            pick_reg  <= PICK_HIGH;
                            state_reg <= ST_PK0;
                        end
                        default:
                        begin
                            high_reg  <= srt_val;
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= $signed(s_tdata);
        end
        if (state_reg == ST_RWAIT)
        begin
            del_val_reg <= $signed(ring_rd_data);
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            m_tuser_reg <= {band, ready_reg};
            m_data_reg  <= {band && (sample_reg >= mid_reg), high_reg, mid_reg, low_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = {7'd0, m_data_reg};

endmodule
`default_nettype wire
